FILE: design/cabb_pkg.sv
`timescale 1ns / 1ps

package cabb_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_BITMAP_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_BITMAP_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_PLACE_X       = 3'd4;
    localparam logic [2:0] CFG_PLACE_Y       = 3'd5;

    localparam int CFG_W = 13;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;

    // Input item
    typedef struct packed {
        logic [31:0] source_pixel;
        logic [31:0] dest_pixel;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [23:0] blended_pixel;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [23:0] source_index;
        logic        last;
        logic        window_empty;
    } t_result;

    // Per-pixel bookkeeping worked out by the front
    typedef struct packed {
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [23:0] source_index;
        logic        last;
        logic        window_empty;
    } t_meta;

    // Queue entry: pixels still to blend plus their bookkeeping
    typedef struct packed {
        logic [31:0] source_pixel;
        logic [23:0] dest_rgb;
        t_meta       meta;
    } t_job;

endpackage

FILE: design/clipped_alpha_blend_blit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Payload
// input     in         i_push / o_full              i_item   (source_pixel, dest_pixel)
// result    out        o_empty / i_pop              o_result (blended_pixel .. window_empty)
// config    in         i_cfg_we, i_cfg_idx          i_cfg_wdata (13 bits)
//
// One pixel per cycle sustained while o_full is low; a result passes the queue, then both blend stages.
// The blend is two registered stages (8x8 products, then divide by 255) behind a
// four-entry queue, so input keeps flowing while a result waits to be popped.
// After reset and after each register write, o_full stays high
// while the clipped window and first source index are recomputed.
// Synchronous active-low reset restores default registers and the window origin.

module clipped_alpha_blend_blit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [cabb_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    output logic                       o_full,
    input  cabb_pkg::t_in_item         i_item,
    output logic                       o_empty,
    input  logic                       i_pop,
    output cabb_pkg::t_result          o_result
);

    logic           q_push, q_full, q_valid, q_pop;
    cabb_pkg::t_job q_in_job, q_out_job;

    // Front: config, clipping, window position
    cabb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job)
    );

    // Decoupling queue
    cabb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // Back: blend pipeline and output register
    cabb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_result  (o_result)
    );

endmodule

FILE: design/cabb_front.sv
`timescale 1ns / 1ps

module cabb_front #(
    parameter int MAX_DIM = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [cabb_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    input  cabb_pkg::t_in_item         i_item,
    output logic                       o_full,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output cabb_pkg::t_job             o_q_job
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int SW = ((DW > cabb_pkg::CFG_W) ? DW : cabb_pkg::CFG_W) + 2;
    localparam int PW = (2 * DW > 24) ? 2 * DW : 24;
    localparam logic [1:0] GEO_LAT = 2'd2;

    typedef struct packed {
        logic [DW-1:0] start;
        logic [DW-1:0] skip;
        logic [DW-1:0] count;
    } t_axis;

    // Size register clamped to the largest supported dimension
    function automatic logic [DW-1:0] dim(input logic [cabb_pkg::CFG_W-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return (w > SW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(v);
    endfunction

    // One axis of the clip: screen start, skipped source pixels, length
    function automatic t_axis clip_axis(input logic [cabb_pkg::CFG_W-1:0] pos_raw,
                                        input logic [cabb_pkg::CFG_W-1:0] len_raw,
                                        input logic [cabb_pkg::CFG_W-1:0] lim_raw);
        logic signed [SW-1:0] pos;
        logic signed [SW-1:0] len;
        logic signed [SW-1:0] lim;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] skip;
        logic signed [SW-1:0] cnt;
        t_axis                res;
        pos  = SW'(signed'(pos_raw));
        len  = SW'(dim(len_raw));
        lim  = SW'(dim(lim_raw));
        lo   = pos;
        hi   = pos + len;
        skip = '0;
        if (lo < 0) begin
            skip = -lo;
            lo   = '0;
        end
        if (hi > lim) begin
            hi = lim;
        end
        cnt       = (hi > lo) ? (hi - lo) : '0;
        res.start = DW'(lo);
        res.skip  = DW'(skip);
        res.count = DW'(cnt);
        return res;
    endfunction

    // Configuration registers
    logic [cabb_pkg::CFG_W-1:0] r_screen_w, r_screen_h, r_bitmap_w, r_bitmap_h;
    logic [cabb_pkg::CFG_W-1:0] r_place_x, r_place_y;
    logic                       cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_idx inside {cabb_pkg::CFG_SCREEN_WIDTH,
        cabb_pkg::CFG_SCREEN_HEIGHT, cabb_pkg::CFG_BITMAP_WIDTH,
        cabb_pkg::CFG_BITMAP_HEIGHT, cabb_pkg::CFG_PLACE_X, cabb_pkg::CFG_PLACE_Y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= cabb_pkg::CFG_W'(640);
            r_screen_h <= cabb_pkg::CFG_W'(480);
            r_bitmap_w <= cabb_pkg::CFG_W'(64);
            r_bitmap_h <= cabb_pkg::CFG_W'(64);
            r_place_x  <= '0;
            r_place_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cabb_pkg::CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_wdata;
                cabb_pkg::CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_wdata;
                cabb_pkg::CFG_BITMAP_WIDTH:  r_bitmap_w <= i_cfg_wdata;
                cabb_pkg::CFG_BITMAP_HEIGHT: r_bitmap_h <= i_cfg_wdata;
                cabb_pkg::CFG_PLACE_X:       r_place_x  <= i_cfg_wdata;
                cabb_pkg::CFG_PLACE_Y:       r_place_y  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Geometry settles through both geometry stages after a write or reset; hold off input meanwhile
    logic [1:0] r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= GEO_LAT;
        end else if (cfg_hit) begin
            r_busy <= GEO_LAT;
        end else if (r_busy != 2'd0) begin
            r_busy <= r_busy - 2'd1;
        end
    end

    // Geometry stage 1: clipped window per axis
    t_axis         n_ax, n_ay;
    t_axis         r_ax, r_ay;
    logic [DW-1:0] r_bw, r_bh;
    logic          r_geo_empty;

    assign n_ax = clip_axis(r_place_x, r_bitmap_w, r_screen_w);
    assign n_ay = clip_axis(r_place_y, r_bitmap_h, r_screen_h);

    always_ff @(posedge i_clk) begin
        r_ax        <= n_ax;
        r_ay        <= n_ay;
        r_bw        <= dim(r_bitmap_w);
        r_bh        <= dim(r_bitmap_h);
        r_geo_empty <= (n_ax.count == '0) || (n_ay.count == '0);
    end

    // Geometry stage 2: source index of the first window pixel (top row, bottom-up)
    logic [DW-1:0] top_row;
    logic [PW-1:0] base_prod;
    logic [23:0]   r_base0;

    assign top_row   = r_bh - DW'(1) - r_ay.skip;
    assign base_prod = PW'(r_bw) * PW'(top_row);

    always_ff @(posedge i_clk) begin
        r_base0 <= 24'(base_prod + PW'(r_ax.skip));
    end

    // Window position
    logic [DW-1:0] r_col, r_row;
    logic [23:0]   r_base;
    logic          accept, col_last, row_last;
    logic [23:0]   cur_base;
    logic [DW:0]   x_sum, y_sum;

    assign o_full   = (r_busy != 2'd0) || i_q_full;
    assign accept   = i_push && !o_full;
    assign cur_base = (r_row == '0) ? r_base0 : r_base;
    assign col_last = (r_col == r_ax.count - DW'(1));
    assign row_last = (r_row == r_ay.count - DW'(1));
    assign x_sum    = {1'b0, r_ax.start} + {1'b0, r_col};
    assign y_sum    = {1'b0, r_ay.start} + {1'b0, r_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && !r_geo_empty) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + DW'(1);
            end else begin
                r_col <= r_col + DW'(1);
            end
        end
    end

    // Base index of the current row; rows go downward in the stored bitmap
    always_ff @(posedge i_clk) begin
        if (accept && !r_geo_empty && col_last) begin
            r_base <= cur_base - 24'(r_bw);
        end
    end

    // Queue entry
    always_comb begin
        o_q_push                   = accept;
        o_q_job.source_pixel       = i_item.source_pixel;
        o_q_job.dest_rgb           = i_item.dest_pixel[23:0];
        if (r_geo_empty) begin
            o_q_job.meta              = '0;
            o_q_job.meta.window_empty = 1'b1;
        end else begin
            o_q_job.meta.dest_x       = 12'(x_sum);
            o_q_job.meta.dest_y       = 12'(y_sum);
            o_q_job.meta.source_index = cur_base + 24'(r_col);
            o_q_job.meta.last         = col_last && row_last;
            o_q_job.meta.window_empty = 1'b0;
        end
    end

    // No transfer while geometry is still settling
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy != 2'd0) |-> !o_q_push)
        else $error("cabb_front: item taken while geometry settles");

    // The final pixel sends the position back to the window origin
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_job.meta.last && !cfg_hit) |=> (r_col == '0 && r_row == '0))
        else $error("cabb_front: position did not wrap after last pixel");

endmodule

FILE: design/cabb_queue.sv
`timescale 1ns / 1ps

module cabb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cabb_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cabb_pkg::t_job o_job
);

    localparam int AW = (cabb_pkg::QDEPTH > 1) ? $clog2(cabb_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(cabb_pkg::QDEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(cabb_pkg::QDEPTH - 1);

    cabb_pkg::t_job r_mem [cabb_pkg::QDEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(cabb_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // The front must never push into a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("cabb_queue: push while full");

endmodule

FILE: design/cabb_back.sv
`timescale 1ns / 1ps

module cabb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  cabb_pkg::t_job    i_q_job,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output cabb_pkg::t_result o_result
);

    // Divide by 255 for values below 65280
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [15:0] t;
        t = n + 16'd1 + (n >> 8);
        return t[15:8];
    endfunction

    // a*s + (255-a)*d + 127 for one channel
    function automatic logic [15:0] mix(input logic [7:0] a, input logic [7:0] s,
                                        input logic [7:0] d);
        logic [7:0] na;
        na = 8'd255 - a;
        return (16'(a) * 16'(s)) + (16'(na) * 16'(d)) + 16'd127;
    endfunction

    logic              r_v1, r_v2;
    logic [15:0]       r_sum_r, r_sum_g, r_sum_b;
    cabb_pkg::t_meta   r_meta1;
    logic              ready1, ready2;
    logic [7:0]        alpha;

    assign ready2  = !r_v2 || i_pop;
    assign ready1  = !r_v1 || ready2;
    assign o_q_pop = i_q_valid && ready1;
    assign o_empty = !r_v2;
    assign alpha   = i_q_job.source_pixel[31:24];

    // Stage 1: weighted sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sum_r <= mix(alpha, i_q_job.source_pixel[23:16], i_q_job.dest_rgb[23:16]);
            r_sum_g <= mix(alpha, i_q_job.source_pixel[15:8],  i_q_job.dest_rgb[15:8]);
            r_sum_b <= mix(alpha, i_q_job.source_pixel[7:0],   i_q_job.dest_rgb[7:0]);
            r_meta1 <= i_q_job.meta;
        end
    end

    // Stage 2: scale back to bytes, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && ready2) begin
            if (r_meta1.window_empty) begin
                o_result.blended_pixel <= '0;
            end else begin
                o_result.blended_pixel <= {div255(r_sum_r), div255(r_sum_g),
                                           div255(r_sum_b)};
            end
            o_result.dest_x       <= r_meta1.dest_x;
            o_result.dest_y       <= r_meta1.dest_y;
            o_result.source_index <= r_meta1.source_index;
            o_result.last         <= r_meta1.last;
            o_result.window_empty <= r_meta1.window_empty;
        end
    end

    // A stage-1 item blocked by a held result stays put
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !ready2) |=> r_v1)
        else $error("cabb_back: stage 1 item lost under stall");

endmodule
